// ===== hdl/hsn_pkg.sv =====
// ----------------------------------------------------------------------------
// hsn_pkg
// Shared types, codes and constants of the height map normal generator.
// ----------------------------------------------------------------------------
package hsn_pkg;

    localparam int MAX_WIDTH_DEF  = 256;
    localparam int MAX_HEIGHT_DEF = 256;

    localparam int MOD_STEPS = 8;
    localparam int NBR_COUNT = 8;
    localparam int SQ_STEPS  = 31;
    localparam int DIV_STEPS = 15;

    localparam int SUM_W  = 53;
    localparam int V_W    = 61;
    localparam int LEN_W  = 31;
    localparam int NUM_W  = 45;
    localparam int MAG_W  = 26;

    localparam logic [SUM_W-1:0] Z_SQUARE = 53'd4261478400;
    localparam logic [MAG_W-1:0] Z_MAG    = 26'd65280;
    localparam logic [14:0]      Q_ONE_Q  = 15'd16384;
    localparam logic [15:0]      Q_ONE    = 16'd16384;

    localparam logic FUNC_LOAD    = 1'b0;
    localparam logic FUNC_COMPUTE = 1'b1;

    localparam logic [2:0] PM_SB_TRIPLE = 3'd0;
    localparam logic [2:0] PM_TC_TRIPLE = 3'd1;
    localparam logic [2:0] PM_SB_DOUBLE = 3'd2;
    localparam logic [2:0] PM_TC_DOUBLE = 3'd3;
    localparam logic [2:0] PM_DXT5      = 3'd4;

    localparam logic [1:0] REG_BUMP_SCALE   = 2'd0;
    localparam logic [1:0] REG_PACK_MODE    = 2'd1;
    localparam logic [1:0] REG_FRAME_WIDTH  = 2'd2;
    localparam logic [1:0] REG_FRAME_HEIGHT = 2'd3;

    // neighbour order of the read sweep
    localparam logic [2:0] NB_UL = 3'd0;
    localparam logic [2:0] NB_U  = 3'd1;
    localparam logic [2:0] NB_UR = 3'd2;
    localparam logic [2:0] NB_L  = 3'd3;
    localparam logic [2:0] NB_R  = 3'd4;
    localparam logic [2:0] NB_DL = 3'd5;
    localparam logic [2:0] NB_D  = 3'd6;
    localparam logic [2:0] NB_DR = 3'd7;

    typedef enum logic [3:0] {
        S_IDLE, S_MOD, S_NBR, S_READ, S_VX, S_VY, S_SQX, S_SQY,
        S_SUM, S_SQRT, S_DINIT, S_DIV, S_PACK
    } t_state;

    typedef enum logic [3:0] {
        OP_NONE, OP_LOAD, OP_START, OP_MOD, OP_NBR, OP_READ, OP_RLAST, OP_VX,
        OP_VY, OP_SQX, OP_SQY, OP_SUM, OP_SQRT, OP_DINIT, OP_DIV, OP_PACK
    } t_op;

    typedef struct packed {
        t_op        op;
        logic [2:0] nbr;
    } t_cmd;

    typedef struct packed {
        logic out_busy;
    } t_stat;

    function automatic logic [15:0] sbias(input logic signed [15:0] n);
        logic signed [16:0] t;
        t = 17'(n) + 17'sd16385;
        return 16'(t >>> 1);
    endfunction

endpackage

// ===== hdl/hsn_ram.sv =====
// ----------------------------------------------------------------------------
// hsn_ram
// Generic single-port RAM with registered read data.
// ----------------------------------------------------------------------------
module hsn_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 65536
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hdl/hsn_ctrl.sv =====
// ----------------------------------------------------------------------------
// hsn_ctrl
// Sequencer: steps the datapath through wrap, reads, gradient, root, divide and pack.
// ----------------------------------------------------------------------------
module hsn_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    input  logic          i_in_func,
    output logic          o_in_ready,
    input  hsn_pkg::t_stat i_stat,
    output hsn_pkg::t_cmd  o_cmd
);
    import hsn_pkg::*;

    t_state     r_state, n_state;
    logic [4:0] r_cnt, n_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid && i_in_func == FUNC_COMPUTE) n_state = S_MOD;
            end
            S_MOD:   if (r_cnt == 5'(MOD_STEPS - 1)) n_state = S_NBR;
            S_NBR:   n_state = S_READ;
            S_READ:  if (r_cnt == 5'(NBR_COUNT)) n_state = S_VX;
            S_VX:    n_state = S_VY;
            S_VY:    n_state = S_SQX;
            S_SQX:   n_state = S_SQY;
            S_SQY:   n_state = S_SUM;
            S_SUM:   n_state = S_SQRT;
            S_SQRT:  if (r_cnt == 5'(SQ_STEPS - 1)) n_state = S_DINIT;
            S_DINIT: n_state = S_DIV;
            S_DIV:   if (r_cnt == 5'(DIV_STEPS - 1)) n_state = S_PACK;
            S_PACK:  if (!i_stat.out_busy) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
        n_cnt = (n_state != r_state) ? 5'd0 : r_cnt + 5'd1;
    end

    always_comb begin
        o_cmd.op   = OP_NONE;
        o_cmd.nbr  = r_cnt[2:0];
        o_in_ready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.op = (i_in_func == FUNC_COMPUTE) ? OP_START : OP_LOAD;
                end
            end
            S_MOD:   o_cmd.op = OP_MOD;
            S_NBR:   o_cmd.op = OP_NBR;
            S_READ:  o_cmd.op = (r_cnt == 5'(NBR_COUNT)) ? OP_RLAST : OP_READ;
            S_VX:    o_cmd.op = OP_VX;
            S_VY:    o_cmd.op = OP_VY;
            S_SQX:   o_cmd.op = OP_SQX;
            S_SQY:   o_cmd.op = OP_SQY;
            S_SUM:   o_cmd.op = OP_SUM;
            S_SQRT:  o_cmd.op = OP_SQRT;
            S_DINIT: o_cmd.op = OP_DINIT;
            S_DIV:   o_cmd.op = OP_DIV;
            S_PACK:  o_cmd.op = i_stat.out_busy ? OP_NONE : OP_PACK;
            default: o_cmd.op = OP_NONE;
        endcase
    end

`ifndef ASSERT_OFF
    a_pack_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.op == OP_PACK |-> !i_stat.out_busy)
        else $error("result written over a waiting beat");
    a_sqrt_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SQRT && r_cnt == 5'(SQ_STEPS - 1)) |=> r_state == S_DINIT)
        else $error("root sweep length wrong");
    a_div_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_DIV |-> r_cnt < 5'(DIV_STEPS))
        else $error("divide sweep overrun");
    a_busy_noready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> !o_in_ready)
        else $error("input taken mid compute");
`endif

endmodule

// ===== hdl/hsn_dpath.sv =====
// ----------------------------------------------------------------------------
// hsn_dpath
// Datapath: registers, height store, wrap, Sobel, root, divide and packing.
// ----------------------------------------------------------------------------
module hsn_dpath #(
    parameter int MAX_WIDTH  = hsn_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = hsn_pkg::MAX_HEIGHT_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  hsn_pkg::t_cmd  i_cmd,
    output hsn_pkg::t_stat o_stat,
    input  logic           i_cfg_valid,
    input  logic [1:0]     i_cfg_index,
    input  logic [15:0]    i_cfg_data,
    input  logic [7:0]     i_pos_x,
    input  logic [7:0]     i_pos_y,
    input  logic [7:0]     i_height_sample,
    output logic           o_out_valid,
    input  logic           i_out_ready,
    output logic [63:0]    o_out_data
);
    import hsn_pkg::*;

    localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
    localparam int AW    = $clog2(DEPTH);

    logic [15:0] r_bump_scale;
    logic [2:0]  r_pack_mode;
    logic [8:0]  r_frame_width, r_frame_height;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bump_scale   <= 16'd256;
            r_pack_mode    <= PM_SB_TRIPLE;
            r_frame_width  <= 9'd256;
            r_frame_height <= 9'd256;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                REG_BUMP_SCALE:   r_bump_scale   <= i_cfg_data;
                REG_PACK_MODE:    r_pack_mode    <= i_cfg_data[2:0];
                REG_FRAME_WIDTH:  r_frame_width  <= i_cfg_data[8:0];
                REG_FRAME_HEIGHT: r_frame_height <= i_cfg_data[8:0];
                default: ;
            endcase
        end
    end

    logic [8:0] eff_w, eff_h;
    always_comb begin
        eff_w = r_frame_width;
        if (r_frame_width == 9'd0) eff_w = 9'd1;
        else if (32'(r_frame_width) > 32'(MAX_WIDTH)) eff_w = 9'(MAX_WIDTH);
        eff_h = r_frame_height;
        if (r_frame_height == 9'd0) eff_h = 9'd1;
        else if (32'(r_frame_height) > 32'(MAX_HEIGHT)) eff_h = 9'(MAX_HEIGHT);
    end

    // wrap reduction, one dividend bit a cycle
    logic [7:0] r_mx, r_my;
    logic [8:0] r_rx, r_ry, r_w, r_h;
    logic [9:0] tx, ty;
    assign tx = {r_rx, r_mx[7]};
    assign ty = {r_ry, r_my[7]};

    logic [8:0] r_xl, r_xc, r_xr, r_yu, r_yc, r_yd;
    logic [9:0] cx_inc, cy_inc;
    assign cx_inc = 10'(r_rx) + 10'd1;
    assign cy_inc = 10'(r_ry) + 10'd1;

    always_ff @(posedge i_clk) begin
        unique case (i_cmd.op)
            OP_START: begin
                r_mx <= i_pos_x;
                r_my <= i_pos_y;
                r_rx <= '0;
                r_ry <= '0;
                r_w  <= eff_w;
                r_h  <= eff_h;
            end
            OP_MOD: begin
                r_mx <= r_mx << 1;
                r_my <= r_my << 1;
                r_rx <= (tx >= 10'(r_w)) ? 9'(tx - 10'(r_w)) : tx[8:0];
                r_ry <= (ty >= 10'(r_h)) ? 9'(ty - 10'(r_h)) : ty[8:0];
            end
            OP_NBR: begin
                r_xc <= r_rx;
                r_yc <= r_ry;
                r_xl <= (r_rx == 9'd0) ? r_w - 9'd1 : r_rx - 9'd1;
                r_yu <= (r_ry == 9'd0) ? r_h - 9'd1 : r_ry - 9'd1;
                r_xr <= (cx_inc == 10'(r_w)) ? 9'd0 : cx_inc[8:0];
                r_yd <= (cy_inc == 10'(r_h)) ? 9'd0 : cy_inc[8:0];
            end
            default: ;
        endcase
    end

    // store access
    logic [8:0]    sel_x, sel_y;
    logic [AW-1:0] rd_addr, wr_addr, ram_addr;
    logic          load_ok, ram_we;
    logic [7:0]    ram_rdata;

    always_comb begin
        case (i_cmd.nbr) inside
            NB_UL, NB_L, NB_DL: sel_x = r_xl;
            NB_U, NB_D:         sel_x = r_xc;
            default:            sel_x = r_xr;
        endcase
        case (i_cmd.nbr) inside
            NB_UL, NB_U, NB_UR: sel_y = r_yu;
            NB_L, NB_R:         sel_y = r_yc;
            default:            sel_y = r_yd;
        endcase
    end

    assign rd_addr  = AW'(sel_y) * AW'(MAX_WIDTH) + AW'(sel_x);
    assign wr_addr  = AW'(i_pos_y) * AW'(MAX_WIDTH) + AW'(i_pos_x);
    assign load_ok  = (32'(i_pos_x) < 32'(MAX_WIDTH)) && (32'(i_pos_y) < 32'(MAX_HEIGHT));
    assign ram_we   = (i_cmd.op == OP_LOAD) && load_ok;
    assign ram_addr = (i_cmd.op == OP_LOAD) ? wr_addr : rd_addr;

    hsn_ram #(.WIDTH(8), .DEPTH(DEPTH)) u_store (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_addr (ram_addr),
        .i_wdata(i_height_sample),
        .o_rdata(ram_rdata)
    );

    // Sobel accumulation, one sample a cycle, in the cycle after its address
    logic               r_acc_en;
    logic [2:0]         r_acc_nbr;
    logic signed [11:0] r_gx, r_gy;
    logic signed [11:0] term1, term2;
    assign term1 = $signed({4'b0, ram_rdata});
    assign term2 = $signed({3'b0, ram_rdata, 1'b0});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc_en <= 1'b0;
        end else begin
            r_acc_en <= (i_cmd.op == OP_READ);
        end
        r_acc_nbr <= i_cmd.nbr;
        if (i_cmd.op == OP_NBR) begin
            r_gx <= '0;
            r_gy <= '0;
        end else if (r_acc_en) begin
            case (r_acc_nbr)
                NB_UL:   begin r_gx <= r_gx - term1; r_gy <= r_gy + term1; end
                NB_U:    r_gy <= r_gy + term2;
                NB_UR:   begin r_gx <= r_gx + term1; r_gy <= r_gy + term1; end
                NB_L:    r_gx <= r_gx - term2;
                NB_R:    r_gx <= r_gx + term2;
                NB_DL:   begin r_gx <= r_gx - term1; r_gy <= r_gy - term1; end
                NB_D:    r_gy <= r_gy - term2;
                default: begin r_gx <= r_gx + term1; r_gy <= r_gy - term1; end
            endcase
        end
    end

    // scale, squares, root, divide
    logic [9:0]       agx, agy;
    logic [MAG_W-1:0] r_ax, r_ay;
    logic             r_sx, r_sy;
    logic [51:0]      r_prod;
    logic [SUM_W-1:0] r_sum;
    logic [V_W-1:0]   r_v, r_root, r_bit, trial;
    logic [LEN_W-1:0] len;
    logic [NUM_W-1:0] r_remx, r_remy, r_remz, r_div;
    logic [14:0]      r_qx, r_qy, r_qz;

    assign agx   = 10'(r_gx[11] ? -r_gx : r_gx);
    assign agy   = 10'(r_gy[11] ? -r_gy : r_gy);
    assign trial = r_root + r_bit;
    assign len   = r_root[LEN_W-1:0];

    always_ff @(posedge i_clk) begin
        case (i_cmd.op)
            OP_VX: begin
                r_ax <= MAG_W'(agx) * MAG_W'(r_bump_scale);
                r_sx <= (r_gx > 12'sd0);
            end
            OP_VY: begin
                r_ay <= MAG_W'(agy) * MAG_W'(r_bump_scale);
                r_sy <= (r_gy > 12'sd0);
            end
            OP_SQX: r_prod <= r_ax * r_ax;
            OP_SQY: begin
                r_sum  <= SUM_W'(r_prod) + Z_SQUARE;
                r_prod <= r_ay * r_ay;
            end
            OP_SUM: begin
                r_v    <= V_W'(r_sum + SUM_W'(r_prod)) << 8;
                r_root <= '0;
                r_bit  <= V_W'(1) << (V_W - 1);
            end
            OP_SQRT: begin
                if (r_v >= trial) begin
                    r_v    <= r_v - trial;
                    r_root <= (r_root >> 1) + r_bit;
                end else begin
                    r_root <= r_root >> 1;
                end
                r_bit <= r_bit >> 2;
            end
            OP_DINIT: begin
                r_remx <= (NUM_W'(r_ax) << 18) + NUM_W'(len >> 1);
                r_remy <= (NUM_W'(r_ay) << 18) + NUM_W'(len >> 1);
                r_remz <= (NUM_W'(Z_MAG) << 18) + NUM_W'(len >> 1);
                r_div  <= NUM_W'(len) << (DIV_STEPS - 1);
                r_qx   <= '0;
                r_qy   <= '0;
                r_qz   <= '0;
            end
            OP_DIV: begin
                if (r_remx >= r_div) r_remx <= r_remx - r_div;
                if (r_remy >= r_div) r_remy <= r_remy - r_div;
                if (r_remz >= r_div) r_remz <= r_remz - r_div;
                r_qx  <= {r_qx[13:0], r_remx >= r_div};
                r_qy  <= {r_qy[13:0], r_remy >= r_div};
                r_qz  <= {r_qz[13:0], r_remz >= r_div};
                r_div <= r_div >> 1;
            end
            default: ;
        endcase
    end

    // packing and output register
    logic [14:0]        cqx, cqy, cqz;
    logic signed [15:0] nx, ny, nz;
    logic [15:0]        pr, pg, pb, pa;

    always_comb begin
        cqx = (r_qx > Q_ONE_Q) ? Q_ONE_Q : r_qx;
        cqy = (r_qy > Q_ONE_Q) ? Q_ONE_Q : r_qy;
        cqz = (r_qz > Q_ONE_Q) ? Q_ONE_Q : r_qz;
        nx  = r_sx ? -$signed(16'(cqx)) : $signed(16'(cqx));
        ny  = r_sy ? -$signed(16'(cqy)) : $signed(16'(cqy));
        nz  = $signed(16'(cqz));
        pr  = '0;
        pg  = '0;
        pb  = '0;
        pa  = '0;
        case (r_pack_mode)
            PM_SB_TRIPLE: begin
                pr = sbias(nx); pg = sbias(ny); pb = sbias(nz); pa = Q_ONE;
            end
            PM_TC_TRIPLE: begin
                pr = nx; pg = ny; pb = nz; pa = Q_ONE;
            end
            PM_SB_DOUBLE: begin
                pr = sbias(nx); pg = sbias(ny); pa = Q_ONE;
            end
            PM_TC_DOUBLE: begin
                pr = nx; pg = ny; pa = Q_ONE;
            end
            PM_DXT5: begin
                pr = sbias(nx); pg = sbias(ny); pb = Q_ONE; pa = sbias(nx);
            end
            default: ;
        endcase
    end

    logic        r_out_valid;
    logic [63:0] r_out_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.op == OP_PACK) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
        if (i_cmd.op == OP_PACK) begin
            r_out_data <= {pa, pb, pg, pr};
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_out_data      = r_out_data;
    assign o_stat.out_busy = r_out_valid && !i_out_ready;

endmodule

// ===== hdl/heightmap_sobel_normal_gen_top.sv =====
// A load beat writes one height; a compute beat runs from acceptance to the result
// register through 8 wrap steps, 8 reads of the single-port height store plus the
// step that takes the last read data, 5 scale and square steps, a 31-step bit-serial
// square root, the divide set-up, a 15-step divide shared by the three components and
// one pack, and the next beat is accepted only once the sequencer is back in idle.
// A waiting result does not block loads but holds the pack step. The height store
// needs no clearing; reading a height never loaded gives an undefined normal.
// ----------------------------------------------------------------------------
// heightmap_sobel_normal_gen_top
// Sobel normal map generator over a stored 8-bit height map.
// ----------------------------------------------------------------------------
module heightmap_sobel_normal_gen_top #(
    parameter int MAX_WIDTH  = hsn_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = hsn_pkg::MAX_HEIGHT_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,  // pos_x, pos_y, height_sample
    input  logic        s_axis_tuser,  // func
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [63:0] m_axis_tdata   // chan_r, chan_g, chan_b, chan_a
);
    import hsn_pkg::*;

    t_cmd  cmd;
    t_stat stat;

    assign o_cfg_ready = 1'b1;

    hsn_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_in_valid(s_axis_tvalid),
        .i_in_func (s_axis_tuser),
        .o_in_ready(s_axis_tready),
        .i_stat    (stat),
        .o_cmd     (cmd)
    );

    hsn_dpath #(.MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT)) u_dpath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_stat         (stat),
        .i_cfg_valid    (i_cfg_valid),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_pos_x        (s_axis_tdata[7:0]),
        .i_pos_y        (s_axis_tdata[15:8]),
        .i_height_sample(s_axis_tdata[23:16]),
        .o_out_valid    (m_axis_tvalid),
        .i_out_ready    (m_axis_tready),
        .o_out_data     (m_axis_tdata)
    );

endmodule
